// ===== sv/ida_pkg.sv =====
`default_nettype none

package ida_pkg;

    localparam int MAG_W     = 32;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int WORK_W    = BCD_W + MAG_W;
    localparam int STEP_BITS = 8;
    localparam int N_STAGES  = MAG_W / STEP_BITS;

    localparam logic [3:0] NUM_DIGITS    = 4'd10;
    localparam logic [3:0] MAX_DIGIT     = 4'd9;
    localparam logic [7:0] CHAR_MINUS    = 8'd45;
    localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

    typedef struct packed {
        logic              neg;
        logic [WORK_W-1:0] work;
    } ida_word_t;

    typedef struct packed {
        logic             neg;
        logic [3:0]       ndig;
        logic [BCD_W-1:0] bcd;
    } ida_text_t;

    // shift-and-add-3 over STEP_BITS binary bits
    function automatic logic [WORK_W-1:0] dabble_steps(input logic [WORK_W-1:0] w_in);
        logic [WORK_W-1:0] w;
        w = w_in;
        for (int s = 0; s < STEP_BITS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (w[MAG_W + 4*d +: 4] >= 4'd5) begin
                    w[MAG_W + 4*d +: 4] = w[MAG_W + 4*d +: 4] + 4'd3;
                end
            end
            w = w << 1;
        end
        return w;
    endfunction

    function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd[4*d +: 4] > MAX_DIGIT) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== sv/int_to_decimal_ascii_unit.sv =====
`default_nettype none

// channel | dir | tdata                 | tuser | tlast
// s_      | in  | value [31:0] signed   | -     | -
// m_      | out | character [7:0]       | -     | last character of the number
//
// one input word gives 1 to 11 output words, one character per cycle unless m_ stalls
// path to output: magnitude, four 8-bit dabble stages, align and output registers
// the output register takes a new number only as the last character of one is taken
// reset clears valid bits, sign and count; no state carries over between numbers
// a stall on m_ backs up through the pipeline without loss or repetition

module int_to_decimal_ascii_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // character
    output logic             m_tlast
);
    import ida_pkg::*;

    logic                 mag_valid_reg;
    ida_word_t            mag_reg;
    ida_word_t            mag_next;

    logic [N_STAGES:0]    vld;
    logic [N_STAGES:0]    rdy;
    ida_word_t            wrd [N_STAGES+1];

    logic                 aln_valid_reg;
    ida_text_t            aln_reg;
    ida_text_t            aln_next;
    logic                 aln_ready;
    logic                 ser_ready;

    logic [BCD_W-1:0]     bcd_c;
    logic [3:0]           ndig_c;
    logic [5:0]           shift_c;

    // sign and magnitude
    always_comb begin
        mag_next.neg  = s_tdata[MAG_W-1];
        mag_next.work = {{BCD_W{1'b0}},
                         s_tdata[MAG_W-1] ? (~s_tdata + 32'd1) : s_tdata};
    end

    assign s_tready = !mag_valid_reg || rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_valid_reg <= 1'b0;
        end else if (s_tready) begin
            mag_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            mag_reg <= mag_next;
        end
    end

    assign vld[0] = mag_valid_reg;
    assign wrd[0] = mag_reg;

    for (genvar g = 0; g < N_STAGES; g++) begin : g_dabble
        ida_dabble_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (vld[g]),
            .in_ready (rdy[g]),
            .in_word  (wrd[g]),
            .out_valid(vld[g+1]),
            .out_ready(rdy[g+1]),
            .out_word (wrd[g+1])
        );
    end

    // leading-zero strip: count digits and move the first one to the top
    always_comb begin
        bcd_c  = wrd[N_STAGES].work[WORK_W-1 -: BCD_W];
        ndig_c = 4'd1;
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd_c[4*d +: 4] != 4'd0) begin
                ndig_c = 4'(d + 1);
            end
        end
        shift_c       = {NUM_DIGITS - ndig_c, 2'b00};
        aln_next.neg  = wrd[N_STAGES].neg;
        aln_next.ndig = ndig_c;
        aln_next.bcd  = bcd_c << shift_c;
    end

    assign aln_ready     = !aln_valid_reg || ser_ready;
    assign rdy[N_STAGES] = aln_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aln_valid_reg <= 1'b0;
        end else if (aln_ready) begin
            aln_valid_reg <= vld[N_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (aln_ready && vld[N_STAGES]) begin
            aln_reg <= aln_next;
        end
    end

    ida_serializer u_ser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(aln_valid_reg),
        .in_ready(ser_ready),
        .in_text (aln_reg),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    a_ndig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        aln_valid_reg |-> aln_reg.ndig != 4'd0 && aln_reg.ndig <= NUM_DIGITS)
        else $error("aligned digit count out of range");

    a_lead_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        aln_valid_reg && aln_reg.ndig != 4'd1 |-> aln_reg.bcd[BCD_W-1 -: 4] != 4'd0)
        else $error("leading zero left after alignment");

    a_align_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        aln_valid_reg && !ser_ready |=> aln_valid_reg && $stable(aln_reg))
        else $error("aligned word lost while stalled");

endmodule

`default_nettype wire

// ===== sv/ida_dabble_stage.sv =====
`default_nettype none

module ida_dabble_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ida_pkg::ida_word_t in_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ida_pkg::ida_word_t     out_word
);
    import ida_pkg::*;

    logic      valid_reg;
    ida_word_t word_reg;
    ida_word_t word_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        word_next.neg  = in_word.neg;
        word_next.work = dabble_steps(in_word.work);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    a_digits_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> bcd_ok(word_reg.work[WORK_W-1 -: BCD_W]))
        else $error("bcd digit out of range after dabble stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(word_reg))
        else $error("dabble stage lost a stalled word");

    a_in_top_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> word_reg.work[WORK_W-1 -: 4] <= 4'd4)
        else $error("leading bcd digit exceeds 32-bit range");

endmodule

`default_nettype wire

// ===== sv/ida_serializer.sv =====
`default_nettype none

module ida_serializer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ida_pkg::ida_text_t in_text,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,  // character
    output logic                    m_tlast
);
    import ida_pkg::*;

    logic             out_valid_reg;
    logic             minus_reg;
    logic [3:0]       rem_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic             last_c;

    assign last_c   = !minus_reg && (rem_reg == 4'd1);
    assign in_ready = !out_valid_reg || (m_tready && last_c);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            minus_reg     <= 1'b0;
            rem_reg       <= '0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
            if (in_valid) begin
                minus_reg <= in_text.neg;
                rem_reg   <= in_text.ndig;
                bcd_reg   <= in_text.bcd;
            end
        end else if (m_tready) begin
            if (minus_reg) begin
                minus_reg <= 1'b0;
            end else begin
                rem_reg <= rem_reg - 4'd1;
                bcd_reg <= bcd_reg << 4;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = minus_reg ? CHAR_MINUS : {CHAR_DIGIT_HI, bcd_reg[BCD_W-1 -: 4]};
    assign m_tlast  = last_c;

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> rem_reg != 4'd0 && rem_reg <= NUM_DIGITS)
        else $error("digit count out of range");

    a_digit_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !minus_reg |-> bcd_reg[BCD_W-1 -: 4] <= MAX_DIGIT)
        else $error("emitted digit is not decimal");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(rem_reg)
            && $stable(minus_reg))
        else $error("serializer advanced while stalled");

endmodule

`default_nettype wire
